@@ hw/rtl/cfsrch_pkg.sv @@
// Shared types and constants for the case-folding substring search block.
`default_nettype none

package cfsrch_pkg;

   localparam int CHAR_W          = 16;
   localparam int IDX_W           = 31;
   localparam int LEN_W           = 4;
   localparam int CFG_W           = 64;
   localparam int CSR_IDX_W       = 3;
   localparam int REG_CHARS       = 8;
   localparam int PATTERN_MAX_DEF = 8;

   localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAT_LO   = 3'd0,
      REG_PAT_HI   = 3'd1,
      REG_ALT_LO   = 3'd2,
      REG_ALT_HI   = 3'd3,
      REG_PAT_LEN  = 3'd4,
      REG_CASE_INS = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [REG_CHARS-1:0][CHAR_W-1:0] pat;
      logic [REG_CHARS-1:0][CHAR_W-1:0] alt;
      logic [LEN_W-1:0]                 len;
      logic                             case_ins;
   } cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              first;
      logic              last;
      logic [IDX_W-1:0]  base_index;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_index;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/cfsrch_cfg.sv @@
// Configuration register file: pattern, alternate pattern, length and mode.
`default_nettype none

module cfsrch_cfg
   import cfsrch_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   output cfg_type                   cfg
);

   logic [CFG_W-1:0] pat_lo_ff, pat_hi_ff, alt_lo_ff, alt_hi_ff;
   logic [LEN_W-1:0] len_ff;
   logic             case_ins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff   <= '0;
         pat_hi_ff   <= '0;
         alt_lo_ff   <= '0;
         alt_hi_ff   <= '0;
         len_ff      <= '0;
         case_ins_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PAT_LO:   pat_lo_ff   <= csr_data;
            REG_PAT_HI:   pat_hi_ff   <= csr_data;
            REG_ALT_LO:   alt_lo_ff   <= csr_data;
            REG_ALT_HI:   alt_hi_ff   <= csr_data;
            REG_PAT_LEN:  len_ff      <= csr_data[LEN_W-1:0];
            REG_CASE_INS: case_ins_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg.pat      = {pat_hi_ff, pat_lo_ff};
   assign cfg.alt      = {alt_hi_ff, alt_lo_ff};
   assign cfg.len      = len_ff;
   assign cfg.case_ins = case_ins_ff;

endmodule

`default_nettype wire

@@ hw/rtl/cfsrch_core.sv @@
// Search state: character window, counters, first-match latch and compare.
`default_nettype none

module cfsrch_core
   import cfsrch_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   localparam int MAX_LEN = (PATTERN_MAX < REG_CHARS) ? PATTERN_MAX : REG_CHARS;

   logic [CHAR_W-1:0] win_ff [MAX_LEN];
   logic [CHAR_W-1:0] win_in [MAX_LEN];
   logic [IDX_W-1:0]  seen_ff, seen_in, seen_cur;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic              latched_ff, latched_in, latched_cur;
   logic [IDX_W-1:0]  idx_ff, idx_in, idx_cur;

   logic [LEN_W-1:0]   eff_len;
   logic [MAX_LEN-1:0] eq [MAX_LEN];
   logic               hit, hit_l;
   logic [IDX_W:0]     sum;
   logic [IDX_W-1:0]   idx_hit;

   always_comb begin
      win_in[0] = item.character;
      for (int i = 1; i < MAX_LEN; i++) begin
         win_in[i] = item.first ? '0 : win_ff[i-1];
      end
      seen_cur    = item.first ? '0 : seen_ff;
      seen_in     = (seen_cur == IDX_MAX) ? seen_cur : seen_cur + 1'b1;
      base_in     = item.first ? item.base_index : base_ff;
      latched_cur = item.first ? 1'b0 : latched_ff;
      idx_cur     = item.first ? '0 : idx_ff;
      eff_len     = (cfg.len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cfg.len;
   end

   // per window slot k and pattern char j
   always_comb begin
      for (int k = 0; k < MAX_LEN; k++) begin
         for (int j = 0; j < MAX_LEN; j++) begin
            eq[k][j] = (win_in[k] == cfg.pat[j]) ||
                       (cfg.case_ins && (win_in[k] == cfg.alt[j]));
         end
      end
   end

   // pattern char j lines up with window slot len-1-j
   always_comb begin
      hit   = 1'b0;
      hit_l = 1'b0;
      for (int l = 1; l <= MAX_LEN; l++) begin
         hit_l = 1'b1;
         for (int j = 0; j < l; j++) begin
            hit_l = hit_l & eq[l-1-j][j];
         end
         if (eff_len == LEN_W'(l)) begin
            hit = hit_l;
         end
      end
   end

   always_comb begin
      sum     = {1'b0, base_in} + {1'b0, seen_in - IDX_W'(eff_len)};
      idx_hit = sum[IDX_W] ? IDX_MAX : sum[IDX_W-1:0];
      latched_in = latched_cur;
      idx_in     = idx_cur;
      if (!latched_cur) begin
         if (eff_len == '0) begin
            latched_in = 1'b1;
            idx_in     = base_in;
         end else if ((seen_in >= IDX_W'(eff_len)) && hit) begin
            latched_in = 1'b1;
            idx_in     = idx_hit;
         end
      end
      result.found       = latched_in;
      result.match_index = latched_in ? idx_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LEN; i++) begin
            win_ff[i] <= '0;
         end
         seen_ff    <= '0;
         base_ff    <= '0;
         latched_ff <= 1'b0;
         idx_ff     <= '0;
      end else if (step) begin
         for (int i = 0; i < MAX_LEN; i++) begin
            win_ff[i] <= win_in[i];
         end
         seen_ff    <= seen_in;
         base_ff    <= base_in;
         latched_ff <= latched_in;
         idx_ff     <= idx_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/case_folding_substring_search_top.sv @@
// Top level of the case-folding substring search: input and result registers.
//
//   channel | direction | transfer when         | payload
//   req_    | in        | req_valid & req_ready | character, first, last, base_index
//   rsp_    | out       | rsp_valid & rsp_ready | found, match_index
//   csr_    | in        | csr_write             | csr_index, csr_data (64 bits)
//
// One character per cycle unless a last character is held for a pending result.
// rsp_valid rises once the last character has left the input register and its
// result is captured in the result register.
// Reset clears configuration and search state; no clearing pass.
// A result not yet taken holds a following last character in the input
// register and drops req_ready behind it; other characters keep flowing.
`default_nettype none

module case_folding_substring_search_top
   import cfsrch_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CHAR_W-1:0]    req_character,
   input  wire logic                 req_first,
   input  wire logic                 req_last,
   input  wire logic [IDX_W-1:0]     req_base_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_found,
   output logic [IDX_W-1:0]          rsp_match_index,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   cfg_type cfg;
   req_type item_ff;
   rsp_type result, rsp_ff;
   logic    in_valid_ff, in_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free, advance, accept;

   cfsrch_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cfsrch_core #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!item_ff.last || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && item_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.character  <= req_character;
         item_ff.first      <= req_first;
         item_ff.last       <= req_last;
         item_ff.base_index <= req_base_index;
      end
      if (advance && item_ff.last) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_match_index = rsp_ff.match_index;

endmodule

`default_nettype wire
